[rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, codes and helpers of the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [3:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [39:0] out_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [3:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic       valid;
    logic       first_k;
    logic       last_k;
    logic       last_elem;
    logic [2:0] row;
    logic [2:0] col;
  } mac_tag_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [39:0] value;
    logic               last;
  } mac_res_t;

  // zero counts as one, anything above the limit counts as the limit
  function automatic logic [3:0] eff_dim(logic [3:0] raw, logic [3:0] lim);
    logic [3:0] v;
    v = (raw == 4'd0) ? 4'd1 : raw;
    if (v > lim) begin
      v = lim;
    end
    return v;
  endfunction

endpackage

[rtl/mma_chan_if.sv]
// ----------------------------------------------------------------------------
// mma_chan_if
// Valid/ready channel carrying one payload of a given type per request.
// ----------------------------------------------------------------------------
interface mma_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/mma_mac.sv]
// ----------------------------------------------------------------------------
// mma_mac
// Registered multiply followed by a 40-bit wrapping accumulator; flags the
// finished dot product on the last inner step.
// ----------------------------------------------------------------------------
module mma_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [15:0]  a_data,
  input  logic signed [15:0]  b_data,
  input  mma_pkg::mac_tag_t   tag,
  output mma_pkg::mac_res_t   res
);

  logic signed [31:0] prod_r;
  mma_pkg::mac_tag_t  tag2_r;
  logic [39:0]        acc_r;
  logic [39:0]        acc_base;
  logic [39:0]        acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r <= tag;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 32'(a_data) * 32'(b_data);
  end

  assign acc_base = tag2_r.first_k ? 40'd0 : acc_r;
  assign acc_nxt  = acc_base + {{8{prod_r[31]}}, prod_r};

  always_ff @(posedge clk) begin
    if (tag2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign res.valid = tag2_r.valid && tag2_r.last_k;
  assign res.row   = tag2_r.row;
  assign res.col   = tag2_r.col;
  assign res.value = acc_nxt;
  assign res.last  = tag2_r.last_elem;

endmodule

[rtl/matrix_multiply_accumulate_top.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_top
// Dense C = A * B over Q8.8 elements held in two single-port-read memories.
// Load request: written to the A or B memory at once.
// Compute request: each result element is computed in turn by the single
// multiply-accumulate unit (one read of each memory per inner step); the next
// element is issued only after the previous one has left the accumulator.
// Reset: dimension registers return to 8; memory contents are not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_top #(
  parameter int MAX_DIM = 8
) (
  input  logic clk,
  input  logic rst_n,
  mma_chan_if.sink   in_chan,
  mma_chan_if.source out_chan,
  mma_chan_if.sink   cfg_chan
);

  localparam int         DEPTH = MAX_DIM * MAX_DIM;
  localparam int         AW    = $clog2(DEPTH);
  localparam logic [3:0] LIM   = (MAX_DIM > 8) ? 4'd8 : 4'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [3:0] dim_m, dim_n, dim_p;

  logic [2:0] i_r, j_r, k_r;
  logic [2:0] i_nxt, j_nxt, k_nxt;

  logic signed [15:0] mem_a [DEPTH];
  logic signed [15:0] mem_b [DEPTH];
  logic signed [15:0] a_rd_r, b_rd_r;

  mma_pkg::in_item_t  req;
  mma_pkg::cfg_req_t  cfg;
  mma_pkg::mac_tag_t  tag1_r, tag1_nxt;
  mma_pkg::mac_res_t  res;
  mma_pkg::out_item_t out_data_r;
  logic               out_valid_r;

  logic          in_fire, load_ok, issue_en, k_last, j_last, i_last;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

  assign req = in_chan.data;
  assign cfg = cfg_chan.data;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mma_pkg::DIM_RESET;
      inner_dim_r <= mma_pkg::DIM_RESET;
      cols_b_r    <= mma_pkg::DIM_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg.index)
        mma_pkg::REG_ROWS_A:    rows_a_r    <= cfg.value;
        mma_pkg::REG_INNER_DIM: inner_dim_r <= cfg.value;
        mma_pkg::REG_COLS_B:    cols_b_r    <= cfg.value;
        default: ;
      endcase
    end
  end

  assign dim_m = mma_pkg::eff_dim(rows_a_r, LIM);
  assign dim_n = mma_pkg::eff_dim(inner_dim_r, LIM);
  assign dim_p = mma_pkg::eff_dim(cols_b_r, LIM);

  // element stores
  assign load_ok = (int'(req.row) < MAX_DIM) && (int'(req.col) < MAX_DIM);
  assign wr_addr = AW'(int'(req.row) * MAX_DIM + int'(req.col));

  always_ff @(posedge clk) begin
    if (in_fire && load_ok && req.cmd == mma_pkg::CMD_LOAD_A) begin
      mem_a[wr_addr] <= req.value;
    end
    if (issue_en) begin
      a_rd_r <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && load_ok && req.cmd == mma_pkg::CMD_LOAD_B) begin
      mem_b[wr_addr] <= req.value;
    end
    if (issue_en) begin
      b_rd_r <= mem_b[rd_addr_b];
    end
  end

  assign rd_addr_a = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = AW'(int'(k_r) * MAX_DIM + int'(j_r));

  // sequencer
  assign k_last = (k_r == 3'(dim_n - 4'd1));
  assign j_last = (j_r == 3'(dim_p - 4'd1));
  assign i_last = (i_r == 3'(dim_m - 4'd1));

  // a new element starts only once the output register is free
  assign issue_en = (state_r == ST_ISSUE) &&
                    ((k_r != 3'd0) || !out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && req.cmd == mma_pkg::CMD_COMPUTE) begin
          i_nxt     = 3'd0;
          j_nxt     = 3'd0;
          k_nxt     = 3'd0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_en) begin
          if (k_last) begin
            k_nxt     = 3'd0;
            state_nxt = ST_DRAIN;
            if (j_last) begin
              j_nxt = 3'd0;
              i_nxt = i_r + 3'd1;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      ST_DRAIN: begin
        if (res.valid) begin
          state_nxt = res.last ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= 3'd0;
      j_r     <= 3'd0;
      k_r     <= 3'd0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    tag1_nxt.valid     = issue_en;
    tag1_nxt.first_k   = (k_r == 3'd0);
    tag1_nxt.last_k    = k_last;
    tag1_nxt.last_elem = i_last && j_last;
    tag1_nxt.row       = i_r;
    tag1_nxt.col       = j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else begin
      tag1_r <= tag1_nxt;
    end
  end

  mma_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .a_data (a_rd_r),
    .b_data (b_rd_r),
    .tag    (tag1_r),
    .res    (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r.out_row   <= res.row;
      out_data_r.out_col   <= res.col;
      out_data_r.out_value <= res.value;
      out_data_r.last      <= res.last;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule
